// ===== rtl/cdll_pkg.sv =====
// Package for the circular doubly linked list engine.
// Holds the command codes, the transaction structs and the controller state type.
// No dependencies.
package cdll_pkg;

  localparam int NODES_DEFAULT = 256;
  localparam int NODE_W = 8;
  localparam int CMD_W = 2;

  typedef logic [CMD_W-1:0] cmd_code_t;

  localparam cmd_code_t CMD_APPEND = 2'd0;
  localparam cmd_code_t CMD_PUSH = 2'd1;
  localparam cmd_code_t CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] node;
  } cmd_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_echo;
    logic [NODE_W-1:0] head;
    logic              is_empty;
    logic              error;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK1,
    ST_LINK2
  } state_t;

endpackage

// ===== rtl/circular_linked_list_engine_top.sv =====
// Top level of the circular doubly linked list engine.
// Keeps the successor and predecessor links in two synchronous memories.
// Depends on cdll_pkg.
//
//   channel   ports                   handshake
//   command   start, item (cmd_item_t) taken at a clock edge with start high, busy low
//   result    done, result (result_t)  shown for one cycle while done is high
//
// Insert into a non-empty list reads the tail link when the command is taken,
// then writes the four links in ST_LINK1 and ST_LINK2, one write port per memory.
// Empty-list insert and remove finish in ST_LINK1; a refused command stays in ST_IDLE.
// The link reads are issued in the cycle the command is taken.
// Reset clears membership, head and the non-empty flag at once; links need no clearing.
// The receiver cannot stall, so done is never held off.
module circular_linked_list_engine_top
  import cdll_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  cmd_item_t item,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  // Only indices that fit the node field can ever be addressed.
  localparam int POOL = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
  localparam int PTR_W = $clog2(POOL);
  localparam logic [NODE_W:0] POOL_LIM = (NODE_W + 1)'(POOL);

  typedef logic [PTR_W-1:0] ptr_t;

  state_t state, state_next;

  logic [POOL-1:0]   member;
  ptr_t              head_node;
  logic              list_nonempty;
  cmd_code_t         cmd_q;
  logic [NODE_W-1:0] node_q;

  logic [PTR_W-1:0] next_mem [POOL];
  logic [PTR_W-1:0] prev_mem [POOL];
  ptr_t             next_rd, prev_rd;

  logic accept, in_range, is_insert_in, refuse, is_insert_q, finish;
  ptr_t node_in, node_ptr;
  ptr_t next_raddr, prev_raddr;
  logic next_we, prev_we;
  ptr_t next_waddr, next_wdata, prev_waddr, prev_wdata;
  ptr_t head_next;
  logic nonempty_next;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;

  assign node_in = item.node[PTR_W-1:0];
  assign in_range = ({1'b0, item.node} < POOL_LIM);
  assign is_insert_in = (item.command == CMD_APPEND) || (item.command == CMD_PUSH);

  always_comb begin
    refuse = 1'b1;
    if (in_range) begin
      if (is_insert_in) begin
        refuse = member[node_in];
      end else if (item.command == CMD_REMOVE) begin
        refuse = !member[node_in];
      end
    end
  end

  assign node_ptr = node_q[PTR_W-1:0];
  assign is_insert_q = (cmd_q == CMD_APPEND) || (cmd_q == CMD_PUSH);

  // An insert reads the tail from the head's predecessor; a remove reads both neighbors.
  assign prev_raddr = (item.command == CMD_REMOVE) ? node_in : head_node;
  assign next_raddr = node_in;

  // Link memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (accept) begin
      next_rd <= next_mem[next_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (accept) begin
      prev_rd <= prev_mem[prev_raddr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !refuse) begin
          state_next = ST_LINK1;
        end
      end
      ST_LINK1: begin
        if (is_insert_q && list_nonempty) begin
          state_next = ST_LINK2;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LINK2: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory writes per state.
  always_comb begin
    next_we = 1'b0;
    prev_we = 1'b0;
    next_waddr = node_ptr;
    next_wdata = node_ptr;
    prev_waddr = node_ptr;
    prev_wdata = node_ptr;
    finish = 1'b0;
    case (state)
      ST_IDLE: begin
      end
      ST_LINK1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        if (is_insert_q) begin
          if (list_nonempty) begin
            next_wdata = head_node;
            prev_wdata = prev_rd;
          end else begin
            finish = 1'b1;
          end
        end else begin
          // Bridge the predecessor and the successor of the removed node.
          next_waddr = prev_rd;
          next_wdata = next_rd;
          prev_waddr = next_rd;
          prev_wdata = prev_rd;
          finish = 1'b1;
        end
      end
      ST_LINK2: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        next_waddr = prev_rd;
        prev_waddr = head_node;
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    head_next = head_node;
    nonempty_next = list_nonempty;
    if (is_insert_q) begin
      nonempty_next = 1'b1;
      if (!list_nonempty || (cmd_q == CMD_PUSH)) begin
        head_next = node_ptr;
      end
    end else if (head_node == node_ptr) begin
      if (next_rd == node_ptr) begin
        head_next = '0;
        nonempty_next = 1'b0;
      end else begin
        head_next = next_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      member <= '0;
      head_node <= '0;
      list_nonempty <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (accept && refuse) begin
        done <= 1'b1;
      end
      if (finish) begin
        done <= 1'b1;
        head_node <= head_next;
        list_nonempty <= nonempty_next;
        member[node_ptr] <= is_insert_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= item.command;
      node_q <= item.node;
      if (refuse) begin
        result.node_echo <= item.node;
        result.head <= list_nonempty ? NODE_W'(head_node) : '0;
        result.is_empty <= !list_nonempty;
        result.error <= 1'b1;
      end
    end else if (finish) begin
      result.node_echo <= node_q;
      result.head <= nonempty_next ? NODE_W'(head_next) : '0;
      result.is_empty <= !nonempty_next;
      result.error <= 1'b0;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a command is still in progress");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == !list_nonempty))
    else $error("reported empty flag disagrees with list state");

  a_link2_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINK2) |-> ($past(state) == ST_LINK1))
    else $error("second link write not preceded by the first");

  a_refused_stable: assert property (@(posedge clk) disable iff (rst)
    (done && result.error) |-> ($stable(member) && $stable(head_node)))
    else $error("refused command changed list state");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    !list_nonempty |-> (head_node == '0))
    else $error("empty list with nonzero head");

endmodule
